>>> rtl/efsr_pkg.sv
// Package for the escaped frame sensor receiver.
// Holds the frame constants, the status codes and the command type passed
// from the front end to the back end. Depends on nothing.
package efsr_pkg;

	// Frame buffer size in bytes and the width of the saturating byte counter
	localparam int BUF_BYTES = 32;
	localparam int CNT_W     = $clog2(BUF_BYTES + 1);

	// Command queue depth between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Framing characters
	localparam logic [7:0] CH_ESC   = 8'h5C;
	localparam logic [7:0] CH_START = 8'h24;
	localparam logic [7:0] CH_END   = 8'h2A;

	// Header decode masks
	localparam logic [7:0] HDR_WORD_MASK   = 8'h80;
	localparam logic [3:0] HDR_MUX_MASK    = 4'h0F;
	localparam logic [2:0] HDR_SENSOR_MASK = 3'h7;

	// Result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_CHECKSUM = 2'd1;
	localparam logic [1:0] ST_SHORT    = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	// Operations the front end hands to the back end
	typedef enum logic [1:0] {
		OP_STORE = 2'd0,
		OP_CLEAR = 2'd1,
		OP_EMIT  = 2'd2
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} cmd_t;

endpackage

>>> rtl/efsr_front.sv
// Front end: removes byte stuffing and classifies each received byte.
// Produces at most one command per beat for the queue. Uses efsr_pkg.
module efsr_front
	import efsr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       q_full,
	input  logic [7:0] rx_byte,
	output logic       cmd_push,
	output cmd_t       cmd
);

	logic esc_pending_q;
	logic esc_pending_d;
	logic accept;
	logic has_cmd;

	assign accept = in_valid && !q_full;

	// Escape decode
	always_comb begin
		esc_pending_d = esc_pending_q;
		has_cmd       = 1'b0;
		cmd.op        = OP_STORE;
		cmd.data      = rx_byte;
		if (rx_byte == CH_ESC) begin
			if (esc_pending_q) begin
				has_cmd       = 1'b1;
				esc_pending_d = 1'b0;
			end else begin
				esc_pending_d = 1'b1;
			end
		end else if (esc_pending_q) begin
			// unknown escapes are dropped and the escape stays pending
			if (rx_byte == CH_START) begin
				has_cmd       = 1'b1;
				cmd.op        = OP_CLEAR;
				esc_pending_d = 1'b0;
			end else if (rx_byte == CH_END) begin
				has_cmd       = 1'b1;
				cmd.op        = OP_EMIT;
				esc_pending_d = 1'b0;
			end
		end else begin
			has_cmd = 1'b1;
		end
	end

	assign cmd_push = accept && has_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_pending_q <= 1'b0;
		end else if (accept) begin
			esc_pending_q <= esc_pending_d;
		end
	end

endmodule

>>> rtl/efsr_queue.sv
// Short command queue between the front end and the back end.
// Register-file FIFO of QDEPTH commands. Uses efsr_pkg.
module efsr_queue
	import efsr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head_cmd,
	output logic empty,
	output logic full
);

	cmd_t              mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign empty    = (count_q == '0);
	assign full     = (count_q == QCNT_W'(QDEPTH));
	assign head_cmd = mem[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("queue push while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("queue pop while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue fill count beyond depth");

endmodule

>>> rtl/efsr_back.sv
// Back end: keeps the frame state, executes queued commands and registers
// one decoded result per frame end. Uses efsr_pkg.
module efsr_back
	import efsr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        head_cmd,
	input  logic        q_empty,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [3:0]  mux_number,
	output logic [2:0]  sensor_number,
	output logic        is_word,
	output logic [31:0] value_bits
);

	logic [CNT_W-1:0] byte_count_q;
	logic [7:0]       xor_q;
	logic [7:0]       header_q;
	logic [31:0]      payload_q;
	logic             overflow_q;
	logic             out_valid_q;

	logic [1:0]       res_status;
	logic             res_word;
	logic [1:0]       lane;
	logic             is_emit;

	assign is_emit = (head_cmd.op == OP_EMIT);
	// an emit waits for a free output slot; other commands never wait
	assign pop = !q_empty && (!is_emit || !out_valid_q || !out_stall);

	// Byte lane of the payload word: frame byte k goes to lane 4-k
	assign lane = 2'(3'd4 - byte_count_q[2:0]);

	// Frame checks
	always_comb begin
		res_word = (header_q & HDR_WORD_MASK) != 8'h00;
		if (overflow_q) begin
			res_status = ST_OVERFLOW;
		end else if (byte_count_q < CNT_W'(2) || (res_word && byte_count_q < CNT_W'(5))) begin
			res_status = ST_SHORT;
		end else if (xor_q != 8'h00) begin
			res_status = ST_CHECKSUM;
		end else begin
			res_status = ST_OK;
		end
	end

	// Frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			xor_q        <= '0;
			header_q     <= '0;
			payload_q    <= '0;
			overflow_q   <= 1'b0;
		end else if (pop) begin
			case (head_cmd.op)
				OP_STORE: begin
					xor_q <= xor_q ^ head_cmd.data;
					if (byte_count_q == CNT_W'(BUF_BYTES)) begin
						overflow_q <= 1'b1;
					end else begin
						if (byte_count_q == '0) begin
							header_q <= head_cmd.data;
						end else if (byte_count_q <= CNT_W'(4)) begin
							payload_q[{lane, 3'b000} +: 8] <=
								payload_q[{lane, 3'b000} +: 8] | head_cmd.data;
						end
						byte_count_q <= byte_count_q + 1'b1;
					end
				end
				OP_CLEAR: begin
					byte_count_q <= '0;
					xor_q        <= '0;
					header_q     <= '0;
					payload_q    <= '0;
					overflow_q   <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// Output register handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && is_emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload, zeroed on any error
	always_ff @(posedge clk) begin
		if (pop && is_emit) begin
			status        <= res_status;
			mux_number    <= '0;
			sensor_number <= '0;
			is_word       <= 1'b0;
			value_bits    <= '0;
			if (res_status == ST_OK) begin
				mux_number    <= header_q[6:3] & HDR_MUX_MASK;
				sensor_number <= header_q[2:0] & HDR_SENSOR_MASK;
				is_word       <= res_word;
				value_bits    <= res_word ? payload_q : {24'h000000, payload_q[31:24]};
			end
		end
	end

	assign out_valid = out_valid_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q <= CNT_W'(BUF_BYTES))
		else $error("byte count beyond buffer size");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		overflow_q |-> byte_count_q == CNT_W'(BUF_BYTES))
		else $error("overflow flagged with buffer not full");

	a_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q)
		else $error("result dropped while stalled");

endmodule

>>> rtl/escaped_frame_sensor_receiver_core.sv
// Top level of the escaped frame sensor receiver.
// Connects front end, command queue and back end. Uses efsr_pkg.

// Takes one serial byte per beat and accepts a byte every cycle while the
// four-entry command queue has room. Byte stuffing is removed in the front
// end; the back end keeps the frame state and, on each backslash-star,
// registers one result (status, mux and sensor numbers, value). An accepted
// byte passes through the command queue before it reaches the frame state,
// and a result appears the cycle after its end marker leaves the queue.
// Only end markers wait on a stalled output, so the input stalls only once
// the queue fills behind a held result.
module escaped_frame_sensor_receiver_core
	import efsr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [3:0]  mux_number,
	output logic [2:0]  sensor_number,
	output logic        is_word,
	output logic [31:0] value_bits
);

	cmd_t front_cmd;
	cmd_t head_cmd;
	logic cmd_push;
	logic cmd_pop;
	logic q_empty;
	logic q_full;

	assign in_stall = q_full;

	efsr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.q_full   (q_full),
		.rx_byte  (rx_byte),
		.cmd_push (cmd_push),
		.cmd      (front_cmd)
	);

	efsr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_cmd (front_cmd),
		.pop      (cmd_pop),
		.head_cmd (head_cmd),
		.empty    (q_empty),
		.full     (q_full)
	);

	efsr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_cmd      (head_cmd),
		.q_empty       (q_empty),
		.pop           (cmd_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.mux_number    (mux_number),
		.sensor_number (sensor_number),
		.is_word       (is_word),
		.value_bits    (value_bits)
	);

endmodule

>>> bench/escaped_frame_sensor_receiver_core_test.sv
// Testbench for escaped_frame_sensor_receiver_core: random byte-stuffed frames
// checked against a built-in deframer model. Uses efsr_pkg and the RTL only.
module escaped_frame_sensor_receiver_core_test
	import efsr_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_BYTES = 1000;
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  mux_number;
		logic [2:0]  sensor_number;
		logic        is_word;
		logic [31:0] value_bits;
	} reading_t;

	// Deframer model plus the queue of readings it still expects to see
	class frame_scoreboard_t;
		bit          escape_pending;
		int          byte_count;
		logic [7:0]  xor_accum;
		logic [7:0]  header_byte;
		logic [31:0] payload_word;
		bit          overflowed;
		reading_t    expected_readings[$];
		int          errors;
		int          checked;
		int          status_seen[4];

		function void clear_frame();
			byte_count   = 0;
			xor_accum    = '0;
			header_byte  = '0;
			payload_word = '0;
			overflowed   = 0;
		endfunction

		function void store_byte(logic [7:0] b);
			xor_accum ^= b;
			if (byte_count >= BUF_BYTES) begin
				overflowed = 1;
				return;
			end
			if (byte_count == 0)
				header_byte = b;
			else if (byte_count <= 4)
				payload_word |= {24'b0, b} << (8 * (4 - byte_count));
			byte_count++;
		endfunction

		function reading_t decode_frame();
			reading_t r;
			bit       word;
			word = (header_byte & HDR_WORD_MASK) != 0;
			r = '0;
			if (overflowed)
				r.status = ST_OVERFLOW;
			else if (byte_count < 2 || (word && byte_count < 5))
				r.status = ST_SHORT;
			else if (xor_accum != 0)
				r.status = ST_CHECKSUM;
			else
				r.status = ST_OK;
			if (r.status != ST_OK)
				return r;
			r.mux_number    = 4'(header_byte >> 3) & HDR_MUX_MASK;
			r.sensor_number = header_byte[2:0] & HDR_SENSOR_MASK;
			r.is_word       = word;
			r.value_bits    = word ? payload_word : {24'b0, payload_word[31:24]};
			return r;
		endfunction

		// One accepted input beat
		function void note_byte(logic [7:0] b);
			if (b == CH_ESC) begin
				if (escape_pending) begin
					store_byte(b);
					escape_pending = 0;
				end else begin
					escape_pending = 1;
				end
			end else if (escape_pending) begin
				// unknown escapes are dropped and leave the escape open
				if (b == CH_START) begin
					clear_frame();
					escape_pending = 0;
				end else if (b == CH_END) begin
					escape_pending = 0;
					expected_readings.push_back(decode_frame());
				end
			end else begin
				store_byte(b);
			end
		endfunction

		// One accepted output beat
		function void check_result(reading_t got);
			reading_t want;
			if (expected_readings.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display(
						"ERROR: unexpected reading: status %0d mux %0d sensor %0d word %0d value %h",
						got.status, got.mux_number, got.sensor_number, got.is_word,
						got.value_bits);
				return;
			end
			want = expected_readings.pop_front();
			status_seen[got.status]++;
			if (got.status !== want.status || got.mux_number !== want.mux_number ||
					got.sensor_number !== want.sensor_number ||
					got.is_word !== want.is_word ||
					got.value_bits !== want.value_bits) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display(
						"ERROR: reading %0d expected status %0d mux %0d sensor %0d word %0d value %h",
						checked, want.status, want.mux_number, want.sensor_number,
						want.is_word, want.value_bits);
					$display(
						"       got      status %0d mux %0d sensor %0d word %0d value %h",
						got.status, got.mux_number, got.sensor_number, got.is_word,
						got.value_bits);
				end
			end
			checked++;
		endfunction

		function int pending();
			return expected_readings.size();
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [1:0]  status;
	logic [3:0]  mux_number;
	logic [2:0]  sensor_number;
	logic        is_word;
	logic [31:0] value_bits;

	frame_scoreboard_t sb;
	int                cycles = 0;
	int                sent = 0;
	bit                steady = 0;
	logic [7:0]        frame_body[$];

	escaped_frame_sensor_receiver_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.mux_number   (mux_number),
		.sensor_number(sensor_number),
		.is_word      (is_word),
		.value_bits   (value_bits)
	);

	always #6 clk = ~clk;

	// Run-away guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("escaped_frame_sensor_receiver_core verification failed");
			$finish;
		end
	end

	function automatic int pick_gap();
		return steady ? 0 : $urandom_range(0, 8);
	endfunction

	// Frame content leans on the framing characters
	function automatic logic [7:0] pick_payload();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return CH_ESC;
		if (r < 16)
			return CH_START;
		if (r < 24)
			return CH_END;
		return 8'($urandom);
	endfunction

	// Drive one beat and hold it until it is taken
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_byte(b);
		sent++;
	endtask

	task automatic send_stuffed(input logic [7:0] b);
		if (b == CH_ESC)
			send_byte(CH_ESC);
		send_byte(b);
	endtask

	task automatic send_end();
		send_byte(CH_ESC);
		send_byte(CH_END);
	endtask

	// Send frame_body with a trailing checksum, optionally corrupted
	task automatic send_frame(input bit restart, input bit good_sum);
		logic [7:0] sum;
		sum = '0;
		if (restart) begin
			send_byte(CH_ESC);
			send_byte(CH_START);
		end
		foreach (frame_body[i]) begin
			sum ^= frame_body[i];
			send_stuffed(frame_body[i]);
		end
		if (!good_sum)
			sum ^= 8'($urandom_range(1, 255));
		send_stuffed(sum);
		send_end();
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Output side: random stall before each beat, then take it
	initial begin
		int       gap;
		reading_t got;
		@(posedge arst_n);
		forever begin
			gap = pick_gap();
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do
				@(posedge clk);
			while (!(out_valid && !out_stall));
			got = '{status, mux_number, sensor_number, is_word, value_bits};
			sb.check_result(got);
		end
	end

	initial begin
		int         r;
		int         n;
		logic [7:0] b;
		sb = new();
		sb.clear_frame();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// End marker on an empty frame
		send_end();
		// Word frame, all header bits set, framing characters as data
		frame_body = '{8'hFF, CH_ESC, CH_START, CH_END, 8'h00};
		send_frame(1, 1);
		// Unknown escape stays open, then the end marker repeats the frame
		send_byte(CH_ESC);
		send_byte(8'h41);
		send_byte(CH_END);
		// Byte frame, zero header
		frame_body = '{8'h00, 8'hFF};
		send_frame(1, 1);

		// Hold off until every reading is back
		wait_drained();

		// Random frames mixed with noise
		while (sent < RANDOM_BYTES + 23) begin
			r = $urandom_range(0, 99);
			if (r < 5) begin
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
			end else if (r < 9) begin
				b = 8'($urandom);
				if (b == CH_ESC || b == CH_START || b == CH_END)
					b = 8'h00;
				send_byte(CH_ESC);
				send_byte(b);
			end else if (r < 13) begin
				send_end();
			end else if (r < 16) begin
				// stub frame: header only or nothing
				send_byte(CH_ESC);
				send_byte(CH_START);
				if ($urandom_range(0, 1) == 1) begin
					b = 8'($urandom);
					send_stuffed(b);
				end
				send_end();
			end else begin
				b = 8'($urandom);
				if ($urandom_range(0, 99) < 6)
					n = $urandom_range(26, 36);
				else if (b[7])
					n = $urandom_range(2, 6);
				else
					n = $urandom_range(0, 4);
				frame_body = '{b};
				repeat (n) frame_body.push_back(pick_payload());
				send_frame($urandom_range(0, 99) >= 5, $urandom_range(0, 99) >= 10);
			end
			if ($urandom_range(0, 29) == 0)
				steady = !steady;
		end

		wait_drained();
		repeat (20) @(posedge clk);

		$display("Sent %0d bytes; checked %0d readings", sent, sb.checked);
		$display("(%0d ok, %0d checksum, %0d short, %0d overflow).",
			sb.status_seen[ST_OK], sb.status_seen[ST_CHECKSUM],
			sb.status_seen[ST_SHORT], sb.status_seen[ST_OVERFLOW]);
		if (sb.errors > 0)
			$display("%0d mismatches in total", sb.errors);
		if (sb.errors == 0)
			$display("escaped_frame_sensor_receiver_core verification clean");
		else
			$display("escaped_frame_sensor_receiver_core verification failed");
		$finish;
	end

endmodule
